/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the sparse dot product unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge out of reset.
`define SDP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdp assertion failed");

// Implication checked on every clock edge out of reset.
`define SDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdp assertion failed");

`endif

/* hdl/sdp_pkg.sv */
// Package for the sparse dot product unit: sizes, payload structs, control types.
// No dependencies.
`timescale 1ns / 1ps

package sdp_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TOK_W       = 20;
  localparam int WGT_W       = 16;
  localparam int PROD_W      = 2 * WGT_W;
  localparam int ACC_W       = 48;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [TOK_W-1:0]        token_id;
    logic signed [WGT_W-1:0] weight;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot_product;
    logic                    store_overflow;
    logic                    sum_saturated;
  } out_t;

  // One stored vector entry.
  typedef struct packed {
    logic [TOK_W-1:0]        token_id;
    logic signed [WGT_W-1:0] weight;
  } entry_t;

  // Sequencer to multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic clr;
  } mac_ctl_t;

endpackage

/* hdl/sdp_store.sv */
// Stored-vector memory: one write port, one read port, registered read data.
// Depends on sdp_pkg.
`timescale 1ns / 1ps

module sdp_store (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [sdp_pkg::ADDR_W-1:0] wr_addr,
  input  sdp_pkg::entry_t       wr_data,
  input  logic                  rd_en,
  input  logic [sdp_pkg::ADDR_W-1:0] rd_addr,
  output sdp_pkg::entry_t       rd_data
);
  import sdp_pkg::*;

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sdp_mac.sv */
// Multiply-accumulate: registered Q4.12 x Q4.12 product, then a 48-bit
// saturating accumulate. Depends on sdp_pkg.
`timescale 1ns / 1ps

module sdp_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sdp_pkg::mac_ctl_t              ctl,
  input  logic signed [sdp_pkg::WGT_W-1:0] op_a,
  input  logic signed [sdp_pkg::WGT_W-1:0] op_b,
  output logic signed [sdp_pkg::ACC_W-1:0] acc,
  output logic                           sat
);
  import sdp_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [ACC_W:0]    sum;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  always_comb begin
    sum     = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod_r);
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (ctl.clr) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end else if (ctl.add_en) begin
      // top two bits differ: out of 48-bit range
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign acc = acc_r;
  assign sat = sat_r;

endmodule

/* hdl/sparse_dot_product_unit.sv */
// Top level of the sparse dot product unit: load/query sequencer, store, MAC.
// Depends on sdp_pkg, sdp_store, sdp_mac, assert_macros.svh.
//
//  channel  ports                 transfer when
//  -------  --------------------  ---------------------------
//  input    start, busy, in_item  start && !busy at clk edge
//  result   out_valid, out_item   out_valid high (one cycle)
//
// Load items are taken in S_IDLE and leave busy low.
// A query item scans the store one entry per cycle (memory read port) up to the
// first match; a match passes through S_MUL and S_ADD to S_FIN, no match goes to
// S_FIN directly. The result of a last query appears in the cycle busy drops.
// Reset is synchronous, active low; stored entries are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module sparse_dot_product_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sdp_pkg::in_t  in_item,
  output logic          out_valid,
  output sdp_pkg::out_t out_item
);
  import sdp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    open_r, open_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [TOK_W-1:0]        q_tok_r;
  logic signed [WGT_W-1:0] q_wgt_r;
  logic                    q_last_r;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r;

  logic                    accept;
  logic [CNT_W-1:0]        load_base;
  logic                    load_fits;
  logic                    wr_en;
  entry_t                  wr_data;
  logic                    rd_en;
  entry_t                  rd_data;
  logic                    hit;
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic                    sat;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  // a load with no vector open starts from an empty store
  assign load_base = open_r ? cnt_r : '0;
  assign load_fits = (load_base < CNT_W'(MAX_ENTRIES));
  assign wr_en     = accept && (in_item.req_type == REQ_LOAD) && load_fits;
  assign wr_data   = '{token_id: in_item.token_id, weight: in_item.weight};
  assign hit       = rd_vld_r && (rd_data.token_id == q_tok_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = 1'b0;
    mac_ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.req_type == REQ_LOAD) begin
            ovf_nxt = open_r ? ovf_r : 1'b0;
            if (load_fits) begin
              cnt_nxt = load_base + CNT_W'(1);
            end else begin
              cnt_nxt = load_base;
              ovf_nxt = 1'b1;
            end
            open_nxt = !in_item.last;
          end else begin
            rd_idx_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_MUL;
        end else if (rd_idx_r < cnt_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = S_ADD;
      end
      S_ADD: begin
        mac_ctl.add_en = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (q_last_r) begin
          out_valid_nxt = 1'b1;
          mac_ctl.clr   = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      open_r      <= 1'b0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_item.req_type == REQ_QUERY)) begin
      q_tok_r  <= in_item.token_id;
      q_wgt_r  <= in_item.weight;
      q_last_r <= in_item.last;
    end
    if (out_valid_nxt) begin
      out_r <= '{dot_product: acc, store_overflow: ovf_r, sum_saturated: sat};
    end
  end

  sdp_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_base[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  sdp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (q_wgt_r),
    .op_b  (rd_data.weight),
    .acc   (acc),
    .sat   (sat)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SDP_ASSERT_IMP(a_out_after_fin, clk, rst_n, out_valid_r, $past(state_r == S_FIN))
  `SDP_ASSERT_IMP(a_rd_in_range, clk, rst_n, rd_en, rd_idx_r < cnt_r)
  `SDP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(MAX_ENTRIES))
  `SDP_ASSERT_IMP(a_mul_has_data, clk, rst_n, state_r == S_MUL, $past(hit))

endmodule

/* test/sparse_dot_product_unit_test.sv */
// Testbench for sparse_dot_product_unit: directed table, then random load/query traffic.
// Depends on sdp_pkg and the RTL of the unit; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module sparse_dot_product_unit_test;
  import sdp_pkg::*;

  localparam longint ACC_HI      = (longint'(1) <<< 47) - 1;
  localparam longint ACC_LO      = -ACC_HI - 1;
  localparam int     QUIET_LIMIT = 50000;
  localparam int     TAIL_CYCLES = MAX_ENTRIES + 16;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  sparse_dot_product_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted copy of the stored vector and the running sum.
  logic        [TOK_W-1:0] vec_tok [MAX_ENTRIES];
  logic signed [WGT_W-1:0] vec_wgt [MAX_ENTRIES];
  int     vec_len     = 0;
  bit     vec_open    = 1'b0;
  bit     vec_dropped = 1'b0;
  longint acc_sum     = 0;
  bit     acc_sat     = 1'b0;

  out_t pending_sums[$];
  int   mismatch_count = 0;
  int   sent           = 0;
  int   idle_pct       = 0;
  int   quiet_cycles   = 0;

  function automatic void dot_step(input in_t it, output bit emit, output out_t res);
    longint sum;
    int     i;
    emit = 1'b0;
    res  = '0;
    if (it.req_type == REQ_LOAD) begin
      if (!vec_open) begin
        vec_len     = 0;
        vec_dropped = 1'b0;
        vec_open    = 1'b1;
      end
      if (vec_len < MAX_ENTRIES) begin
        vec_tok[vec_len] = it.token_id;
        vec_wgt[vec_len] = it.weight;
        vec_len++;
      end else begin
        vec_dropped = 1'b1;
      end
      if (it.last) vec_open = 1'b0;
      return;
    end
    // first matching entry only
    for (i = 0; i < vec_len; i++) begin
      if (vec_tok[i] == it.token_id) begin
        sum = acc_sum + longint'($signed(it.weight)) * longint'($signed(vec_wgt[i]));
        if (sum > ACC_HI) begin
          sum     = ACC_HI;
          acc_sat = 1'b1;
        end else if (sum < ACC_LO) begin
          sum     = ACC_LO;
          acc_sat = 1'b1;
        end
        acc_sum = sum;
        break;
      end
    end
    if (!it.last) return;
    emit               = 1'b1;
    res.dot_product    = acc_sum[ACC_W-1:0];
    res.store_overflow = vec_dropped;
    res.sum_saturated  = acc_sat;
    acc_sum            = 0;
    acc_sat            = 1'b0;
  endfunction

  // Presents one item and waits for its transfer; start stays high for a following item.
  task automatic issue(input logic req, input logic [TOK_W-1:0] tok,
                       input logic [WGT_W-1:0] w, input logic last,
                       input bit typed = 1'b0, input out_t typed_res = '0);
    in_t  it;
    out_t res;
    bit   emit;
    it.req_type = req;
    it.token_id = tok;
    it.weight   = w;
    it.last     = last;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    dot_step(it, emit, res);
    if (emit) pending_sums.push_back(typed ? typed_res : res);
    sent++;
  endtask

  function automatic logic [TOK_W-1:0] pick_token();
    if ($urandom_range(3) == 0) return TOK_W'($urandom);
    return 20'hA5A40 | TOK_W'($urandom_range(31));
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    return WGT_W'($urandom);
  endfunction

  task automatic query_vector(ref logic [TOK_W-1:0] toks[$]);
    int len, k;
    logic [TOK_W-1:0] tk;
    len = $urandom_range(1, 8);
    for (k = 0; k < len; k++) begin
      if (toks.size() != 0 && $urandom_range(99) < 70) tk = toks[$urandom_range(toks.size() - 1)];
      else tk = pick_token();
      issue(REQ_QUERY, tk, pick_weight(), k == len - 1);
    end
  endtask

  task automatic random_phase(input int n_items);
    logic [TOK_W-1:0] vec_toks[$];
    logic [TOK_W-1:0] tk;
    int base, len, r, k;
    base = sent;
    while (sent - base < n_items) begin
      r = $urandom_range(99);
      if (r < 85) begin
        // well-formed: load a vector, then query it; sometimes query mid-load
        len = $urandom_range(1, 12);
        vec_toks.delete();
        for (k = 0; k < len; k++) begin
          tk = pick_token();
          vec_toks.push_back(tk);
          if (r >= 70 && k == len / 2) query_vector(vec_toks);
          issue(REQ_LOAD, tk, pick_weight(), k == len - 1);
        end
        repeat ($urandom_range(1, 3)) query_vector(vec_toks);
      end else begin
        // noise: any mix of loads and queries, last at random
        repeat ($urandom_range(1, 6))
          issue(1'($urandom_range(1)), pick_token(), pick_weight(), 1'($urandom_range(1)));
      end
    end
  endtask

  typedef struct {
    logic             req;
    logic [TOK_W-1:0] tok;
    logic [WGT_W-1:0] w;
    logic             last;
    int               rep;
    bit               typed;
    logic [ACC_W-1:0] dot;
    bit               ovf;
    bit               sat;
  } dir_row_t;

  // rep copies of a row; last and a typed expectation apply to the final copy only
  dir_row_t dir_rows [14] = '{
    '{REQ_QUERY, 20'h00005, 16'h1000, 1'b1, 1,      1'b1, 48'h0,            1'b0, 1'b0},
    '{REQ_LOAD,  20'h00000, 16'h7FFF, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_LOAD,  20'hFFFFF, 16'h8000, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_LOAD,  20'h00000, 16'h0001, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_LOAD,  20'h5A5A5, 16'h8000, 1'b1, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_QUERY, 20'h00000, 16'h7FFF, 1'b1, 1,      1'b1, 48'h0000_3FFF_0001, 1'b0, 1'b0},
    '{REQ_QUERY, 20'hFFFFF, 16'h8000, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_QUERY, 20'h5A5A5, 16'h8000, 1'b1, 1,      1'b1, 48'h0000_8000_0000, 1'b0, 1'b0},
    '{REQ_QUERY, 20'h12345, 16'h7FFF, 1'b1, 1,      1'b1, 48'h0,            1'b0, 1'b0},
    '{REQ_LOAD,  20'h00001, 16'h0001, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_QUERY, 20'h00001, 16'hFFFF, 1'b0, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_QUERY, 20'h00000, 16'h7FFF, 1'b1, 1,      1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{REQ_LOAD,  20'h00002, 16'h7FFF, 1'b1, 1,      1'b0, 48'h0,            1'b0, 1'b0},
    '{REQ_QUERY, 20'h00002, 16'h7FFF, 1'b1, 1,      1'b0, 48'h0,            1'b0, 1'b0}
  };

  initial begin
    int   i, c;
    out_t tres;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, duplicate tokens, query during load, no match
    idle_pct = 0;
    for (i = 0; i < $size(dir_rows); i++) begin
      tres.dot_product    = dir_rows[i].dot;
      tres.store_overflow = dir_rows[i].ovf;
      tres.sum_saturated  = dir_rows[i].sat;
      for (c = 0; c < dir_rows[i].rep; c++)
        issue(dir_rows[i].req, dir_rows[i].tok, dir_rows[i].w,
              dir_rows[i].last && (c == dir_rows[i].rep - 1),
              dir_rows[i].typed && (c == dir_rows[i].rep - 1), tres);
    end

    idle_pct = 15;
    random_phase(189);
    idle_pct = 88;
    random_phase(189);
    idle_pct = 0;
    random_phase(188);
    start <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result: expected none, got dot %h ovf %b sat %b", $time,
                 out_item.dot_product, out_item.store_overflow, out_item.sum_saturated);
        mismatch_count++;
      end else begin
        exp_res = pending_sums.pop_front();
        if (out_item.dot_product !== exp_res.dot_product) begin
          $display("%0t: dot_product expected %h actual %h", $time,
                   exp_res.dot_product, out_item.dot_product);
          mismatch_count++;
        end
        if (out_item.store_overflow !== exp_res.store_overflow) begin
          $display("%0t: store_overflow expected %b actual %b", $time,
                   exp_res.store_overflow, out_item.store_overflow);
          mismatch_count++;
        end
        if (out_item.sum_saturated !== exp_res.sum_saturated) begin
          $display("%0t: sum_saturated expected %b actual %b", $time,
                   exp_res.sum_saturated, out_item.sum_saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sparse_dot_product_unit.f */
+incdir+hdl
hdl/sdp_pkg.sv
hdl/sdp_store.sv
hdl/sdp_mac.sv
hdl/sparse_dot_product_unit.sv
test/sparse_dot_product_unit_test.sv
